[rtl/core/bpfr_pkg.sv]
// ----------------------------------------------------------------------------
// bpfr_pkg: shared types and constants of the block pool free ring
// Pool geometry, field widths, item modes, result codes and small helpers.
// ----------------------------------------------------------------------------
package bpfr_pkg;

  // Pool geometry. The ring has one spare entry so that "empty" (head equal
  // to tail) is never confused with "full".
  localparam int NBLOCKS  = 64;
  localparam int RING_LEN = NBLOCKS + 1;
  localparam int PTR_W    = $clog2(RING_LEN);
  localparam int COUNT_W  = $clog2(NBLOCKS + 1);

  // Field widths fixed by the interface.
  localparam int MODE_W    = 2;
  localparam int SIZE_W    = 16;
  localparam int RES_W     = 7;
  localparam int ID_W      = 6;
  localparam int STATUS_W  = 3;
  localparam int FCOUNT_W  = 7;

  // Common widths for compares and truncations.
  localparam int CMP_W     = (COUNT_W > RES_W) ? COUNT_W : RES_W;
  localparam int FEXT_W    = (COUNT_W > FCOUNT_W) ? COUNT_W : FCOUNT_W;
  localparam int IDEXT_W   = (PTR_W > ID_W) ? PTR_W : ID_W;

  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = SIZE_W'(1024);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_REFILL  = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_SIZE    = 3'd1,
    STAT_RESERVE = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_FILL,
    S_IDLE,
    S_POP
  } state_t;

  // Outcome of one item, as decided from the registers before it.
  typedef struct packed {
    status_t status;
    logic    pop;
    logic    push;
    logic    refill;
  } decision_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(RING_LEN - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Low id bits of a ring index, the value a refill writes there.
  function automatic logic [ID_W-1:0] ring_id(input logic [PTR_W-1:0] p);
    logic [IDEXT_W-1:0] w;
    w = IDEXT_W'(p);
    return w[ID_W-1:0];
  endfunction

  // Count as reported on the 7-bit result fields.
  function automatic logic [FCOUNT_W-1:0] count_field(input logic [COUNT_W-1:0] c);
    logic [FEXT_W-1:0] w;
    w = FEXT_W'(c);
    return w[FCOUNT_W-1:0];
  endfunction

endpackage

[rtl/core/block_pool_free_ring.sv]
// ----------------------------------------------------------------------------
// block_pool_free_ring: fixed-size block pool with a free-id ring
// Free block ids live in a circular ring RAM one entry larger than the pool.
// Allocate pops the id at the head, release pushes an id at the tail, and a
// pool reset rewrites the ring with ids 0 to NBLOCKS-1.
//
//   channel   signals                                        transfer when
//   -------   --------------------------------------------   --------------
//   item in   start, busy, mode, request_size, min_reserve,   start && !busy
//             released_id
//   result    done, status, block_id, used_count, free_count  done
//   config    cfg_we, cfg_wdata (block_size)                  cfg_we
//
// An allocate that pops an id reads the ring RAM, then updates the head
// in S_POP; every other item but a pool reset completes when accepted.
// The result appears on the cycle after the item completes, for exactly one
// cycle.
// A pool reset sweeps every ring RAM entry, one entry a cycle, with busy high,
// then gives its result. The same sweep runs after rst, with no result;
// config writes are taken at any time.
// The receiver cannot stall results; a new item may be taken while the
// previous result is still on the ports.
// ----------------------------------------------------------------------------
module block_pool_free_ring (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bpfr_pkg::MODE_W-1:0]   mode,
  input  logic [bpfr_pkg::SIZE_W-1:0]   request_size,
  input  logic [bpfr_pkg::RES_W-1:0]    min_reserve,
  input  logic [bpfr_pkg::ID_W-1:0]     released_id,
  output logic                          done,
  output logic [bpfr_pkg::STATUS_W-1:0] status,
  output logic [bpfr_pkg::ID_W-1:0]     block_id,
  output logic [bpfr_pkg::FCOUNT_W-1:0] used_count,
  output logic [bpfr_pkg::FCOUNT_W-1:0] free_count,
  input  logic                          cfg_we,
  input  logic [bpfr_pkg::SIZE_W-1:0]   cfg_wdata
);

  bpfr_pkg::state_t state, state_next;

  // Pool bookkeeping.
  logic [bpfr_pkg::SIZE_W-1:0]  block_size;
  logic [bpfr_pkg::PTR_W-1:0]   head, head_next;
  logic [bpfr_pkg::PTR_W-1:0]   tail, tail_next;
  logic [bpfr_pkg::COUNT_W-1:0] free_cnt, free_cnt_next;
  logic [bpfr_pkg::COUNT_W-1:0] used_cnt, used_cnt_next;

  // Refill sweep.
  logic [bpfr_pkg::PTR_W-1:0]   sweep, sweep_next;
  logic                         report_fill, report_fill_next;
  logic                         sweep_last;

  // Result registers.
  logic                          done_next;
  logic [bpfr_pkg::STATUS_W-1:0] status_next;
  logic [bpfr_pkg::ID_W-1:0]     block_id_next;
  logic [bpfr_pkg::FCOUNT_W-1:0] used_count_next;
  logic [bpfr_pkg::FCOUNT_W-1:0] free_count_next;

  // Ring RAM port controls.
  logic                        ram_we;
  logic [bpfr_pkg::PTR_W-1:0]  ram_waddr;
  logic [bpfr_pkg::ID_W-1:0]   ram_wdata;
  logic                        ram_re;
  logic [bpfr_pkg::ID_W-1:0]   ram_rdata;

  logic                  accept;
  bpfr_pkg::decision_t   dec;

  assign accept     = start && (state == bpfr_pkg::S_IDLE);
  assign sweep_last = (sweep == bpfr_pkg::PTR_W'(bpfr_pkg::RING_LEN - 1));

  bpfr_decide u_decide (
    .mode         (mode),
    .request_size (request_size),
    .min_reserve  (min_reserve),
    .block_size   (block_size),
    .free_cnt     (free_cnt),
    .dec          (dec)
  );

  // The ring is read only at the head in the accept cycle of a pop and
  // written only at the tail by a release or at the sweep index by the
  // sweep. One item is in flight at a time, so a read and a write never hit
  // the same entry in the same cycle and no forwarding is needed.
  bpfr_ram #(
    .WIDTH (bpfr_pkg::ID_W),
    .DEPTH (bpfr_pkg::RING_LEN)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (head),
    .rd_data (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bpfr_pkg::S_FILL: begin
        if (sweep_last) begin
          state_next = bpfr_pkg::S_IDLE;
        end
      end
      bpfr_pkg::S_IDLE: begin
        if (accept && dec.pop) begin
          state_next = bpfr_pkg::S_POP;
        end else if (accept && dec.refill) begin
          state_next = bpfr_pkg::S_FILL;
        end
      end
      bpfr_pkg::S_POP: begin
        state_next = bpfr_pkg::S_IDLE;
      end
      default: begin
        state_next = bpfr_pkg::S_IDLE;
      end
    endcase
  end

  // FSM outputs: handshake and ring RAM controls.
  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = released_id;
    ram_re    = 1'b0;
    unique case (state)
      bpfr_pkg::S_FILL: begin
        // write the low id bits of i into entry i
        ram_we    = 1'b1;
        ram_waddr = sweep;
        ram_wdata = bpfr_pkg::ring_id(sweep);
      end
      bpfr_pkg::S_IDLE: begin
        busy   = 1'b0;
        ram_we = accept && dec.push;
        ram_re = accept && dec.pop;
      end
      bpfr_pkg::S_POP: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Pool bookkeeping and result formation.
  always_comb begin
    head_next        = head;
    tail_next        = tail;
    free_cnt_next    = free_cnt;
    used_cnt_next    = used_cnt;
    sweep_next       = sweep;
    report_fill_next = report_fill;
    done_next        = 1'b0;
    status_next      = status;
    block_id_next    = block_id;
    used_count_next  = used_count;
    free_count_next  = free_count;

    unique case (state)
      bpfr_pkg::S_FILL: begin
        sweep_next = bpfr_pkg::ptr_next(sweep);
        if (sweep_last) begin
          // ring now holds ids 0..NBLOCKS-1 in order
          head_next        = '0;
          tail_next        = bpfr_pkg::PTR_W'(bpfr_pkg::NBLOCKS);
          free_cnt_next    = bpfr_pkg::COUNT_W'(bpfr_pkg::NBLOCKS);
          used_cnt_next    = '0;
          report_fill_next = 1'b0;
          done_next        = report_fill;
          status_next      = bpfr_pkg::STAT_OK;
          block_id_next    = '0;
          used_count_next  = '0;
          free_count_next  = bpfr_pkg::count_field(bpfr_pkg::COUNT_W'(bpfr_pkg::NBLOCKS));
        end
      end
      bpfr_pkg::S_IDLE: begin
        if (accept) begin
          if (dec.refill) begin
            // start the sweep; the result comes at its end
            sweep_next       = '0;
            report_fill_next = 1'b1;
          end else if (!dec.pop) begin
            if (dec.push) begin
              tail_next     = bpfr_pkg::ptr_next(tail);
              free_cnt_next = free_cnt + bpfr_pkg::COUNT_W'(1);
              if (used_cnt != '0) begin
                used_cnt_next = used_cnt - bpfr_pkg::COUNT_W'(1);
              end
            end
            done_next       = 1'b1;
            status_next     = dec.status;
            block_id_next   = '0;
            used_count_next = bpfr_pkg::count_field(used_cnt_next);
            free_count_next = bpfr_pkg::count_field(free_cnt_next);
          end
        end
      end
      bpfr_pkg::S_POP: begin
        // head entry is on the RAM read port now
        head_next       = bpfr_pkg::ptr_next(head);
        free_cnt_next   = free_cnt - bpfr_pkg::COUNT_W'(1);
        used_cnt_next   = used_cnt + bpfr_pkg::COUNT_W'(1);
        done_next       = 1'b1;
        status_next     = bpfr_pkg::STAT_OK;
        block_id_next   = ram_rdata;
        used_count_next = bpfr_pkg::count_field(used_cnt_next);
        free_count_next = bpfr_pkg::count_field(free_cnt_next);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bpfr_pkg::S_FILL;
      sweep       <= '0;
      report_fill <= 1'b0;
      head        <= '0;
      tail        <= bpfr_pkg::PTR_W'(bpfr_pkg::NBLOCKS);
      free_cnt    <= bpfr_pkg::COUNT_W'(bpfr_pkg::NBLOCKS);
      used_cnt    <= '0;
      done        <= 1'b0;
      block_size  <= bpfr_pkg::BLOCK_SIZE_RESET;
    end else begin
      state       <= state_next;
      sweep       <= sweep_next;
      report_fill <= report_fill_next;
      head        <= head_next;
      tail        <= tail_next;
      free_cnt    <= free_cnt_next;
      used_cnt    <= used_cnt_next;
      done        <= done_next;
      if (cfg_we) begin
        block_size <= cfg_wdata;
      end
    end
  end

  // Result payload: no reset needed, qualified by done.
  always_ff @(posedge clk) begin
    status     <= status_next;
    block_id   <= block_id_next;
    used_count <= used_count_next;
    free_count <= free_count_next;
  end

endmodule

[rtl/core/bpfr_ram.sv]
// ----------------------------------------------------------------------------
// bpfr_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bpfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/bpfr_decide.sv]
// ----------------------------------------------------------------------------
// bpfr_decide: item decision logic
// Check an incoming item against block size, reserve and ring occupancy.
// ----------------------------------------------------------------------------
module bpfr_decide (
  input  logic [bpfr_pkg::MODE_W-1:0]  mode,
  input  logic [bpfr_pkg::SIZE_W-1:0]  request_size,
  input  logic [bpfr_pkg::RES_W-1:0]   min_reserve,
  input  logic [bpfr_pkg::SIZE_W-1:0]  block_size,
  input  logic [bpfr_pkg::COUNT_W-1:0] free_cnt,
  output bpfr_pkg::decision_t          dec
);

  logic reserve_hit;

  assign reserve_hit = (min_reserve != '0) &&
                       (bpfr_pkg::CMP_W'(free_cnt) <= bpfr_pkg::CMP_W'(min_reserve));

  always_comb begin
    dec.status = bpfr_pkg::STAT_OK;
    dec.pop    = 1'b0;
    dec.push   = 1'b0;
    dec.refill = 1'b0;
    unique case (mode)
      bpfr_pkg::MODE_ALLOC: begin
        // size first, then reserve, then empty
        if (request_size > block_size) begin
          dec.status = bpfr_pkg::STAT_SIZE;
        end else if (reserve_hit) begin
          dec.status = bpfr_pkg::STAT_RESERVE;
        end else if (free_cnt == '0) begin
          dec.status = bpfr_pkg::STAT_EMPTY;
        end else begin
          dec.pop = 1'b1;
        end
      end
      bpfr_pkg::MODE_RELEASE: begin
        if (free_cnt == bpfr_pkg::COUNT_W'(bpfr_pkg::NBLOCKS)) begin
          dec.status = bpfr_pkg::STAT_FULL;
        end else begin
          dec.push = 1'b1;
        end
      end
      bpfr_pkg::MODE_REFILL: begin
        dec.refill = 1'b1;
      end
      default: begin
        // unused mode: no change, status ok
      end
    endcase
  end

endmodule
